@@ design/gdad_pkg.sv @@
`timescale 1ns / 1ps
package gdad_pkg;

  localparam int DAY_COUNT_BITS_DEF = 20;
  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int REM_W   = 9;
  localparam int CENT_W  = 7;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 16'hFFFF;
  localparam logic [REM_W-1:0]   YEAR_DAYS = 9'd365;
  localparam int                 CENTURY   = 100;

  // floor(y / 100) == (y * CENT_RECIP) >> CENT_RECIP_SHIFT for every 16-bit y
  localparam logic [YEAR_W:0]    CENT_RECIP       = 17'd83887;
  localparam int                 CENT_RECIP_SHIFT = 23;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAYS_LONG  = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_FEB   = 5'd28;
  localparam logic [DAY_W-1:0] DAY_FIRST  = 5'd1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic check;
    logic doy_step;
    logic jump;
    logic skip_step;
    logic walk_step;
    logic out_load;
  } gdad_cmd_t;

  typedef struct packed {
    logic bad;
    logic rem_last;
    logic n_ge_rem;
    logic skip_go;
    logic year_max;
    logic walk_done;
    logic out_free;
  } gdad_sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MONTH_FEB: len = DAYS_FEB + {{(DAY_W-1){1'b0}}, leap};
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
      default: len = DAYS_LONG;
    endcase
    return len;
  endfunction

endpackage

@@ design/gdad_in_if.sv @@
`timescale 1ns / 1ps
interface gdad_in_if #(
  parameter int DAY_COUNT_BITS = gdad_pkg::DAY_COUNT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [gdad_pkg::YEAR_W-1:0]   start_year;
  logic [gdad_pkg::MONTH_W-1:0]  start_month;
  logic [gdad_pkg::DAY_W-1:0]    start_day;
  logic [DAY_COUNT_BITS-1:0]     days_to_add;

  modport source (output valid, start_year, start_month, start_day, days_to_add,
                  input ready);
  modport sink   (input valid, start_year, start_month, start_day, days_to_add,
                  output ready);
endinterface

@@ design/gdad_out_if.sv @@
`timescale 1ns / 1ps
interface gdad_out_if;
  logic                          valid;
  logic                          ready;
  logic [gdad_pkg::YEAR_W-1:0]   result_year;
  logic [gdad_pkg::MONTH_W-1:0]  result_month;
  logic [gdad_pkg::DAY_W-1:0]    result_day;
  logic                          bad_date;
  logic                          year_overflow;

  modport source (output valid, result_year, result_month, result_day, bad_date,
                  year_overflow, input ready);
  modport sink   (input valid, result_year, result_month, result_day, bad_date,
                  year_overflow, output ready);
endinterface

@@ design/gdad_datapath.sv @@
`timescale 1ns / 1ps
module gdad_datapath #(
  parameter int DAY_COUNT_BITS = gdad_pkg::DAY_COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [gdad_pkg::YEAR_W-1:0]  start_year,
  input  logic [gdad_pkg::MONTH_W-1:0] start_month,
  input  logic [gdad_pkg::DAY_W-1:0]   start_day,
  input  logic [DAY_COUNT_BITS-1:0]    days_to_add,
  input  gdad_pkg::gdad_cmd_t          cmd,
  output gdad_pkg::gdad_sts_t          sts,
  gdad_out_if.source                   answer
);
  import gdad_pkg::*;

  logic [YEAR_W-1:0]         year;
  logic [YEAR_W-1:0]         dq;
  logic [CENT_W-1:0]         pr;
  logic [MONTH_W-1:0]        month;
  logic [MONTH_W-1:0]        sm;
  logic [DAY_W-1:0]          day;
  logic [DAY_COUNT_BITS-1:0] n;
  logic [REM_W-1:0]          rem;
  logic                      bad;
  logic                      ovf;

  logic [2*YEAR_W:0]         q_prod;
  logic [YEAR_W-1:0]         q_start;
  logic [YEAR_W-1:0]         cent_prod;
  logic [YEAR_W-1:0]         yr_rem;
  logic                      leap_cur;
  logic [YEAR_W-1:0]         y1;
  logic [CENT_W-1:0]         r1;
  logic [YEAR_W-1:0]         q1;
  logic                      leap_nxt;
  logic [REM_W-1:0]          ylen_nxt;
  logic [DAY_W-1:0]          mlen_cur;
  logic [DAY_W-1:0]          left;
  logic [DAY_W-1:0]          mlen_sm1;
  logic [MONTH_W-1:0]        sm1;
  logic                      bad_now;
  logic                      n_fits;

  assign q_prod    = (2*YEAR_W+1)'(start_year) * (2*YEAR_W+1)'(CENT_RECIP);
  assign q_start   = YEAR_W'(q_prod >> CENT_RECIP_SHIFT);
  assign cent_prod = dq * YEAR_W'(CENTURY);
  assign yr_rem    = year - cent_prod;

  assign leap_cur = (year[1:0] == 2'b00) && ((pr != '0) || (dq[1:0] == 2'b00));
  assign y1       = year + 1'b1;
  assign r1       = (pr == CENT_W'(CENTURY - 1)) ? '0 : pr + 1'b1;
  assign q1       = (pr == CENT_W'(CENTURY - 1)) ? dq + 1'b1 : dq;
  assign leap_nxt = (y1[1:0] == 2'b00) && ((r1 != '0) || (q1[1:0] == 2'b00));
  assign ylen_nxt = YEAR_DAYS + {{(REM_W-1){1'b0}}, leap_nxt};

  assign mlen_cur = month_len(month, leap_cur);
  assign left     = mlen_cur - day;
  assign sm1      = sm + 1'b1;
  assign mlen_sm1 = month_len(sm1, leap_cur);
  assign n_fits   = n <= DAY_COUNT_BITS'(left);

  assign bad_now = (month < MONTH_JAN) || (month > MONTH_DEC) || (day == '0) ||
                   (day > mlen_cur);

  assign sts.bad       = bad_now;
  assign sts.rem_last  = sm == MONTH_DEC;
  assign sts.n_ge_rem  = n >= DAY_COUNT_BITS'(rem);
  assign sts.skip_go   = n >= DAY_COUNT_BITS'(ylen_nxt);
  assign sts.year_max  = year == YEAR_MAX;
  assign sts.walk_done = (n == '0) || ovf;
  assign sts.out_free  = !answer.valid || answer.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year  <= start_year;
      month <= start_month;
      day   <= start_day;
      n     <= days_to_add;
      dq    <= q_start;
      pr    <= '0;
      bad   <= 1'b0;
      ovf   <= 1'b0;
    end
    if (cmd.div_step) begin
      pr <= yr_rem[CENT_W-1:0];
    end
    if (cmd.check) begin
      bad <= bad_now;
      rem <= REM_W'(left);
      sm  <= month;
    end
    if (cmd.doy_step) begin
      sm  <= sm1;
      rem <= rem + REM_W'(mlen_sm1);
    end
    if (cmd.jump) begin
      n     <= n - DAY_COUNT_BITS'(rem);
      month <= MONTH_DEC;
      day   <= DAYS_LONG;
    end
    if (cmd.skip_step) begin
      if (year == YEAR_MAX) begin
        ovf <= 1'b1;
      end else begin
        year <= y1;
        pr   <= r1;
        dq   <= q1;
        n    <= n - DAY_COUNT_BITS'(ylen_nxt);
      end
    end
    if (cmd.walk_step) begin
      if (n_fits) begin
        day <= day + n[DAY_W-1:0];
        n   <= '0;
      end else begin
        n   <= n - DAY_COUNT_BITS'(left) - DAY_COUNT_BITS'(1);
        day <= DAY_FIRST;
        if (month == MONTH_DEC) begin
          month <= MONTH_JAN;
          if (year == YEAR_MAX) begin
            ovf <= 1'b1;
          end else begin
            year <= y1;
            pr   <= r1;
            dq   <= q1;
          end
        end else begin
          month <= month + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      answer.valid <= 1'b0;
    end else if (cmd.out_load) begin
      answer.valid <= 1'b1;
    end else if (answer.ready) begin
      answer.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (bad) begin
        answer.result_year  <= '0;
        answer.result_month <= MONTH_JAN;
        answer.result_day   <= DAY_FIRST;
      end else if (ovf) begin
        answer.result_year  <= YEAR_MAX;
        answer.result_month <= MONTH_DEC;
        answer.result_day   <= DAYS_LONG;
      end else begin
        answer.result_year  <= year;
        answer.result_month <= month;
        answer.result_day   <= day;
      end
      answer.bad_date      <= bad;
      answer.year_overflow <= ovf && !bad;
    end
  end

endmodule

@@ design/gdad_ctrl.sv @@
`timescale 1ns / 1ps
module gdad_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output gdad_pkg::gdad_cmd_t cmd,
  input  gdad_pkg::gdad_sts_t sts
);
  import gdad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_DOY,
    S_SKIP,
    S_WALK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.bad ? S_DONE : S_DOY;
      end
      S_DOY: begin
        if (sts.rem_last) begin
          if (sts.n_ge_rem) begin
            cmd.jump   = 1'b1;
            state_next = S_SKIP;
          end else begin
            state_next = S_WALK;
          end
        end else begin
          cmd.doy_step = 1'b1;
        end
      end
      S_SKIP: begin
        if (sts.skip_go) begin
          cmd.skip_step = 1'b1;
          if (sts.year_max) begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_next = S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/gregorian_date_add_days.sv @@
`timescale 1ns / 1ps
// Channel  Role    Fields
// query    sink    start_year, start_month, start_day, days_to_add
// answer   source  result_year, result_month, result_day, bad_date, year_overflow
//
// One item at a time, in order: load (year / 100 by reciprocal multiply),
// the year's remainder by 100, a check, summing the rest of the year month
// by month, skipping whole years, walking months, then loading the result.
// Reset is synchronous and clears the controller and the result valid.
// A held result does not block the next item; only the final load waits.
module gregorian_date_add_days #(
  parameter int DAY_COUNT_BITS = gdad_pkg::DAY_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gdad_in_if.sink    query,
  gdad_out_if.source answer
);
  import gdad_pkg::*;

  gdad_cmd_t cmd;
  gdad_sts_t sts;
  logic      item_ready;

  assign query.ready = item_ready;

  gdad_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (query.valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  gdad_datapath #(
    .DAY_COUNT_BITS (DAY_COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .start_year  (query.start_year),
    .start_month (query.start_month),
    .start_day   (query.start_day),
    .days_to_add (query.days_to_add),
    .cmd         (cmd),
    .sts         (sts),
    .answer      (answer)
  );

endmodule

@@ test/tb_gregorian_date_add_days.sv @@
`timescale 1ns / 1ps
module tb_gregorian_date_add_days;
  import gdad_pkg::*;

  localparam int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF;
  localparam logic [DAY_COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 3000;
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               bad;
    logic               ovf;
  } date_result_t;

  bit clk;
  logic rst;

  gdad_in_if #(.DAY_COUNT_BITS(DAY_COUNT_BITS)) query ();
  gdad_out_if answer ();

  gregorian_date_add_days #(.DAY_COUNT_BITS(DAY_COUNT_BITS)) uut (
    .clk    (clk),
    .rst    (rst),
    .query  (query),
    .answer (answer)
  );

  date_result_t pending_dates[$];
  int src_idle_pct;
  int sink_idle_pct;
  int mismatches;
  int dates_sent;
  int results_checked;
  int bad_seen;
  int ovf_seen;
  int cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_dates.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) begin
    answer.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic bit leap_year(int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int days_in_year(int y);
    return 365 + int'(leap_year(y));
  endfunction

  function automatic int days_in_month(int y, int m);
    return MONTH_DAYS[m-1] + ((m == MONTH_FEB && leap_year(y)) ? 1 : 0);
  endfunction

  function automatic date_result_t advance_date(logic [YEAR_W-1:0] y0,
                                                logic [MONTH_W-1:0] m0,
                                                logic [DAY_W-1:0] d0,
                                                logic [DAY_COUNT_BITS-1:0] cnt);
    date_result_t r;
    int y;
    int m;
    int d;
    int i;
    int doy;
    int left;
    longint n;
    bit ovf;
    y = y0;
    m = m0;
    d = d0;
    n = cnt;
    ovf = 1'b0;
    doy = 0;
    r = '{year: '0, month: MONTH_JAN, day: DAY_FIRST, bad: 1'b1, ovf: 1'b0};
    if (m < MONTH_JAN || m > MONTH_DEC || d < 1 || d > days_in_month(y, m))
      return r;
    for (i = 1; i < m; i++)
      doy += days_in_month(y, i);
    doy += d;
    if (n >= days_in_year(y) - doy) begin
      n -= days_in_year(y) - doy;
      m = MONTH_DEC;
      d = 31;
      while (!ovf && n >= days_in_year(y + 1)) begin
        if (y + 1 > YEAR_MAX) begin
          ovf = 1'b1;
        end else begin
          y++;
          n -= days_in_year(y);
        end
      end
    end
    while (!ovf && n > 0) begin
      left = days_in_month(y, m) - d;
      if (n <= left) begin
        d += int'(n);
        n = 0;
      end else begin
        n -= left + 1;
        d = 1;
        if (m == MONTH_DEC) begin
          m = MONTH_JAN;
          if (y + 1 > YEAR_MAX)
            ovf = 1'b1;
          else
            y++;
        end else begin
          m++;
        end
      end
    end
    if (ovf) begin
      y = YEAR_MAX;
      m = MONTH_DEC;
      d = 31;
    end
    r.year = y[YEAR_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.day = d[DAY_W-1:0];
    r.bad = 1'b0;
    r.ovf = ovf;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    date_result_t want;
    if (!rst && query.valid && query.ready)
      pending_dates.push_back(advance_date(query.start_year, query.start_month,
                                           query.start_day, query.days_to_add));
    if (!rst && answer.valid && answer.ready) begin
      if (pending_dates.size() == 0) begin
        mismatches++;
        $display("%0t: result %0d-%0d-%0d bad=%0b ovf=%0b with nothing expected", $time,
                 answer.result_year, answer.result_month, answer.result_day,
                 answer.bad_date, answer.year_overflow);
      end else begin
        want = pending_dates.pop_front();
        results_checked++;
        bad_seen += want.bad;
        ovf_seen += want.ovf;
        compare_field("result_year", want.year, answer.result_year);
        compare_field("result_month", want.month, answer.result_month);
        compare_field("result_day", want.day, answer.result_day);
        compare_field("bad_date", want.bad, answer.bad_date);
        compare_field("year_overflow", want.ovf, answer.year_overflow);
      end
    end
  end

  task automatic send_date(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                           logic [DAY_W-1:0] d, logic [DAY_COUNT_BITS-1:0] cnt);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      query.valid <= 1'b0;
    end
    @(negedge clk);
    query.valid <= 1'b1;
    query.start_year <= y;
    query.start_month <= m;
    query.start_day <= d;
    query.days_to_add <= cnt;
    do @(posedge clk); while (!query.ready);
    dates_sent++;
  endtask

  // drop valid, then hold until every result is back
  task automatic drain_results();
    @(negedge clk);
    query.valid <= 1'b0;
    while (pending_dates.size() != 0)
      @(posedge clk);
  endtask

  task automatic pick_date(output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
                           output logic [DAY_W-1:0] d);
    int yr;
    int len;
    case ($urandom_range(3))
      0: yr = $urandom_range(65535);
      1: yr = 65535 - $urandom_range(3000);
      2: yr = $urandom_range(655) * 100 + $urandom_range(4) - 1;
      default: yr = $urandom_range(2100);
    endcase
    if (yr < 0)
      yr = 0;
    y = yr[YEAR_W-1:0];
    m = MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN));
    len = days_in_month(yr, m);
    d = ($urandom_range(3) == 0) ? len[DAY_W-1:0] : DAY_W'($urandom_range(len, 1));
  endtask

  task automatic pick_broken_date(output logic [MONTH_W-1:0] m, output logic [DAY_W-1:0] d,
                                  input logic [YEAR_W-1:0] y);
    logic [MONTH_W-1:0] short_months [5];
    int len;
    short_months = '{MONTH_FEB, MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV};
    case ($urandom_range(2))
      0: begin
        m = ($urandom_range(3) == 0) ? 4'd0 : MONTH_W'($urandom_range(15, 13));
        d = DAY_W'($urandom_range(31));
      end
      1: begin
        m = MONTH_W'($urandom_range(15));
        d = '0;
      end
      default: begin
        m = short_months[$urandom_range(4)];
        len = days_in_month(y, m);
        d = DAY_W'($urandom_range(31, len + 1));
      end
    endcase
  endtask

  function automatic logic [DAY_COUNT_BITS-1:0] pick_count();
    case ($urandom_range(9))
      0, 1: return DAY_COUNT_BITS'($urandom_range(COUNT_MAX));
      2, 3, 4, 5: return DAY_COUNT_BITS'($urandom_range(400));
      default: return DAY_COUNT_BITS'($urandom_range(40000));
    endcase
  endfunction

  task automatic test_field_extremes();
    send_date(16'd0, MONTH_JAN, 5'd1, '0);
    send_date(YEAR_MAX, MONTH_DEC, 5'd31, '0);
    send_date(16'd0, MONTH_JAN, 5'd1, COUNT_MAX);
    send_date(16'h5555, 4'd10, 5'd31, 20'hAAAAA);
    send_date(16'hAAAA, 4'd5, 5'd30, 20'h55555);
  endtask

  task automatic test_leap_rules();
    send_date(16'd2000, MONTH_FEB, 5'd29, '0);
    send_date(16'd2024, MONTH_FEB, 5'd28, 1);
    send_date(16'd2100, MONTH_FEB, 5'd28, 1);
    send_date(16'd1900, MONTH_DEC, 5'd31, 59);
    send_date(16'd2023, MONTH_JAN, 5'd1, 364);
    send_date(16'd2023, MONTH_JAN, 5'd1, 365);
    send_date(16'd1999, MONTH_DEC, 5'd31, 366);
    send_date(16'd0, MONTH_FEB, 5'd29, '0);
  endtask

  task automatic test_invalid_dates();
    send_date(16'd2024, 4'd0, 5'd10, 5);
    send_date(16'd2024, 4'd13, 5'd1, 5);
    send_date(16'd2024, 4'd15, 5'd31, COUNT_MAX);
    send_date(16'd2024, 4'd3, 5'd0, 5);
    send_date(16'd2023, MONTH_FEB, 5'd29, '0);
    send_date(16'd2024, MONTH_FEB, 5'd30, '0);
    send_date(16'd2024, MONTH_APR, 5'd31, 10);
  endtask

  task automatic test_year_overflow();
    send_date(YEAR_MAX, MONTH_DEC, 5'd31, 1);
    send_date(YEAR_MAX, MONTH_DEC, 5'd30, 1);
    send_date(YEAR_MAX, MONTH_JAN, 5'd1, 364);
    send_date(YEAR_MAX, MONTH_JAN, 5'd1, 365);
    send_date(16'd64000, 4'd3, 5'd1, COUNT_MAX);
    send_date(16'd65534, MONTH_DEC, 5'd31, 366);
  endtask

  task automatic test_random_traffic(int src_pct, int sink_pct, int count);
    logic [YEAR_W-1:0] y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0] d;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    for (int k = 0; k < count; k++) begin
      pick_date(y, m, d);
      if ($urandom_range(99) < 15)
        pick_broken_date(m, d, y);
      send_date(y, m, d, pick_count());
      if ($urandom_range(29) == 0)
        drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    query.valid = 1'b0;
    query.start_year = '0;
    query.start_month = '0;
    query.start_day = '0;
    query.days_to_add = '0;
    answer.ready = 1'b0;
    src_idle_pct = 23;
    sink_idle_pct = 54;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_leap_rules();
    test_invalid_dates();
    test_year_overflow();
    drain_results();
    test_random_traffic(23, 54, 40);
    test_random_traffic(54, 23, 40);
    test_random_traffic(0, 0, 40);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d dates, checked %0d results (%0d invalid, %0d year overflows)",
             dates_sent, results_checked, bad_seen, ovf_seen);
    $display("idle mixes: sender-light/receiver-heavy, reversed, and back-to-back");
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
design/gdad_pkg.sv
design/gdad_in_if.sv
design/gdad_out_if.sv
design/gdad_datapath.sv
design/gdad_ctrl.sv
design/gregorian_date_add_days.sv
test/tb_gregorian_date_add_days.sv
